// ----- hdl/hcbd_pkg.sv -----
package hcbd_pkg;

	// Field widths fixed by the interface
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 13;
	localparam int VALUE_W = 32;

	// Parameter defaults
	localparam int unsigned MAX_BODY_DEF        = 4096;
	localparam int unsigned SIZE_LINE_LIMIT_DEF = 49;

	localparam logic [COUNT_W-1:0] CAP_RESET = 13'd4096;

	// Frame phase codes
	localparam logic [2:0] PH_LINE  = 3'd0;
	localparam logic [2:0] PH_SKIP  = 3'd1;
	localparam logic [2:0] PH_DATA  = 3'd2;
	localparam logic [2:0] PH_TRAIL = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	// Size line parse steps
	localparam logic [2:0] PS_BLANK  = 3'd0;
	localparam logic [2:0] PS_SIGNED = 3'd1;
	localparam logic [2:0] PS_ZERO   = 3'd2;
	localparam logic [2:0] PS_PREFIX = 3'd3;
	localparam logic [2:0] PS_DIGITS = 3'd4;
	localparam logic [2:0] PS_STOP   = 3'd5;

	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

	// Running state of the size line parser
	typedef struct packed {
		logic [2:0]         step;
		logic [VALUE_W-1:0] value;
		logic               negative;
	} parse_t;

	localparam parse_t PARSE_CLEAR = '{step: PS_BLANK, value: '0, negative: 1'b0};

endpackage

// ----- hdl/hcbd_size_parse.sv -----
module hcbd_size_parse
	import hcbd_pkg::*;
(
	input  parse_t            cur,
	input  logic [BYTE_W-1:0] ch,
	output parse_t            nxt
);

	logic             is_digit;
	logic [3:0]       digit;
	logic [VALUE_W-1:0] acc;
	logic             is_blank;
	logic             is_sign;
	logic             is_x;

	always_comb begin
		is_digit = 1'b1;
		digit    = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			digit = 4'(ch - 8'h30);
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			digit = 4'(ch - 8'h57);
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			digit = 4'(ch - 8'h37);
		end else begin
			is_digit = 1'b0;
		end
	end

	// saturating shift-in of one hex digit
	assign acc = (cur.value > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF : {cur.value[27:0], digit};

	assign is_blank = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0B) || (ch == 8'h0C);
	assign is_sign  = (ch == 8'h2B) || (ch == 8'h2D);
	assign is_x     = (ch == 8'h78) || (ch == 8'h58);

	always_comb begin
		nxt = cur;
		case (cur.step)
			PS_BLANK, PS_SIGNED: begin
				if (cur.step == PS_BLANK && is_blank) begin
					nxt = cur;
				end else if (cur.step == PS_BLANK && is_sign) begin
					nxt.negative = (ch == 8'h2D);
					nxt.step     = PS_SIGNED;
				end else if (ch == 8'h30) begin
					nxt.step = PS_ZERO;
				end else if (is_digit) begin
					nxt.value = acc;
					nxt.step  = PS_DIGITS;
				end else begin
					nxt.step = PS_STOP;
				end
			end
			PS_ZERO: begin
				if (is_x) begin
					nxt.step = PS_PREFIX;
				end else if (is_digit) begin
					nxt.value = acc;
					nxt.step  = PS_DIGITS;
				end else begin
					nxt.step = PS_STOP;
				end
			end
			PS_PREFIX, PS_DIGITS: begin
				if (is_digit) begin
					nxt.value = acc;
					nxt.step  = PS_DIGITS;
				end else begin
					nxt.step = PS_STOP;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ----- hdl/http_chunked_body_deframer.sv -----
// Chunked HTTP body deframer. Feed the raw body one byte per item (mode 0);
// payload bytes come out with data_valid set and a running body_length, and
// one closing item reports finished (zero-size chunk or capacity reached) or
// failed (negative size, or a size line longer than SIZE_LINE_LIMIT chars).
// Size lines are read like strtol base 16: blanks, sign, optional 0x, digits,
// trailing junk ignored. After the end, bytes are swallowed until an item with
// mode 1 restarts the decoder. Apart from that closing item, framing bytes (size
// line, the byte after it and the two trailer bytes) produce no output item.
// Throughput is one byte per clock unless out_stall holds a waiting result;
// an input register is followed by the result register, with the full
// per-byte state update in between. When out_stall holds a waiting result,
// in_stall rises only once the input register is also occupied.
// cfg_wr_data sets the capacity (values above MAX_BODY act as MAX_BODY);
// write it only between bodies or while no item is in flight.
module http_chunked_body_deframer
	import hcbd_pkg::*;
#(
	parameter int unsigned MAX_BODY        = MAX_BODY_DEF,
	parameter int unsigned SIZE_LINE_LIMIT = SIZE_LINE_LIMIT_DEF
)
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [BYTE_W-1:0]  in_byte,

	output logic               out_valid,
	input  logic               out_stall,
	output logic               data_valid,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               finished,
	output logic               failed,
	output logic [COUNT_W-1:0] body_length
);

	localparam int LINE_W = $clog2(SIZE_LINE_LIMIT + 1);

	// capacity register
	logic [COUNT_W-1:0] cap_q;

	// input stage
	logic              valid_s1;
	logic              mode_s1;
	logic [BYTE_W-1:0] byte_s1;

	// decoder state
	logic [2:0]         phase_q;
	parse_t             parse_q;
	logic [LINE_W-1:0]  line_chars_q;
	logic [1:0]         skip_left_q;
	logic [COUNT_W-1:0] chunk_left_q;
	logic [COUNT_W-1:0] delivered_q;

	// next state and result
	logic [2:0]         phase_d;
	parse_t             parse_d;
	parse_t             parse_char;
	logic [LINE_W-1:0]  line_chars_d;
	logic [1:0]         skip_left_d;
	logic [COUNT_W-1:0] chunk_left_d;
	logic [COUNT_W-1:0] delivered_d;
	logic               res_v;
	logic               res_data;
	logic [BYTE_W-1:0]  res_byte;
	logic               res_fin;
	logic               res_fail;

	logic               advance;
	logic               step_en;
	logic [COUNT_W-1:0] cap_eff;
	logic [COUNT_W-1:0] room;
	logic [COUNT_W-1:0] chunk_take;
	logic [COUNT_W-1:0] chunk_dec;
	logic [COUNT_W-1:0] deliv_inc;
	logic [1:0]         skip_dec;
	logic               is_eol;

	// pipeline moves whenever the result register is free or being drained
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step_en  = valid_s1 && advance;

	assign cap_eff = (32'(cap_q) > 32'(MAX_BODY)) ? COUNT_W'(MAX_BODY) : cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			mode_s1 <= mode;
			byte_s1 <= in_byte;
		end
	end

	hcbd_size_parse u_parse (
		.cur (parse_q),
		.ch  (byte_s1),
		.nxt (parse_char)
	);

	assign is_eol     = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);
	assign room       = (cap_eff > delivered_q) ? cap_eff - delivered_q : '0;
	assign chunk_take = (parse_q.value < 32'(room)) ? parse_q.value[COUNT_W-1:0] : room;
	assign chunk_dec  = chunk_left_q - 1'b1;
	assign deliv_inc  = delivered_q + 1'b1;
	assign skip_dec   = (skip_left_q != 2'd0) ? skip_left_q - 2'd1 : skip_left_q;

	always_comb begin
		phase_d      = phase_q;
		parse_d      = parse_q;
		line_chars_d = line_chars_q;
		skip_left_d  = skip_left_q;
		chunk_left_d = chunk_left_q;
		delivered_d  = delivered_q;
		res_v        = 1'b0;
		res_data     = 1'b0;
		res_byte     = '0;
		res_fin      = 1'b0;
		res_fail     = 1'b0;

		if (mode_s1) begin
			// restart: everything but the capacity register
			phase_d      = PH_LINE;
			parse_d      = PARSE_CLEAR;
			line_chars_d = '0;
			skip_left_d  = '0;
			chunk_left_d = '0;
			delivered_d  = '0;
		end else begin
			case (phase_q)
				PH_LINE: begin
					if (is_eol) begin
						if (parse_q.value == '0) begin
							// zero chunk, minus zero included
							phase_d = PH_DONE;
							res_v   = 1'b1;
							res_fin = 1'b1;
						end else if (parse_q.negative) begin
							phase_d  = PH_DONE;
							res_v    = 1'b1;
							res_fail = 1'b1;
						end else begin
							phase_d = PH_SKIP;
						end
					end else if (line_chars_q >= LINE_W'(SIZE_LINE_LIMIT)) begin
						phase_d  = PH_DONE;
						res_v    = 1'b1;
						res_fail = 1'b1;
					end else begin
						line_chars_d = line_chars_q + 1'b1;
						parse_d      = parse_char;
					end
				end
				PH_SKIP: begin
					// chunk clipped to the room left under the capacity
					chunk_left_d = chunk_take;
					if (chunk_take == '0) begin
						phase_d = PH_DONE;
						res_v   = 1'b1;
						res_fin = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					delivered_d  = deliv_inc;
					chunk_left_d = chunk_dec;
					res_v        = 1'b1;
					res_data     = 1'b1;
					res_byte     = byte_s1;
					if (chunk_dec == '0) begin
						if (deliv_inc >= cap_eff) begin
							phase_d = PH_DONE;
							res_fin = 1'b1;
						end else begin
							phase_d     = PH_TRAIL;
							skip_left_d = 2'd2;
						end
					end
				end
				PH_TRAIL: begin
					skip_left_d = skip_dec;
					if (skip_dec == 2'd0) begin
						phase_d      = PH_LINE;
						parse_d      = PARSE_CLEAR;
						line_chars_d = '0;
					end
				end
				default: begin
					// done: swallow bytes until restart
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LINE;
			parse_q      <= PARSE_CLEAR;
			line_chars_q <= '0;
			skip_left_q  <= '0;
			chunk_left_q <= '0;
			delivered_q  <= '0;
		end else if (step_en) begin
			phase_q      <= phase_d;
			parse_q      <= parse_d;
			line_chars_q <= line_chars_d;
			skip_left_q  <= skip_left_d;
			chunk_left_q <= chunk_left_d;
			delivered_q  <= delivered_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= step_en && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res_v) begin
			data_valid  <= res_data;
			out_byte    <= res_byte;
			finished    <= res_fin;
			failed      <= res_fail;
			body_length <= delivered_d;
		end
	end

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled while pipeline has room");

	a_data_chunk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (chunk_left_q != '0))
		else $error("data phase with empty chunk");

	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && !(step_en && mode_s1)) |=> (phase_q == PH_DONE))
		else $error("left done without restart");

	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step_en))
		else $error("result appeared without a processed item");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && failed) |-> (!data_valid && !finished && out_byte == '0))
		else $error("failed result carries data");
`endif

endmodule

// ----- sim/tb_http_chunked_body_deframer.sv -----
module tb_http_chunked_body_deframer
	import hcbd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Two register stages between input and result
	localparam int PIPE_LAT = 2;

	// One delivered result, in port order
	typedef struct packed {
		logic               dv;
		logic [BYTE_W-1:0]  b;
		logic               fin;
		logic               fail;
		logic [COUNT_W-1:0] len;
	} body_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [COUNT_W-1:0] cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	logic [BYTE_W-1:0]  in_byte;
	logic               out_valid;
	logic               out_stall;
	logic               data_valid;
	logic [BYTE_W-1:0]  out_byte;
	logic               finished;
	logic               failed;
	logic [COUNT_W-1:0] body_length;

	http_chunked_body_deframer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_valid  (data_valid),
		.out_byte    (out_byte),
		.finished    (finished),
		.failed      (failed),
		.body_length (body_length)
	);

	// Results the deframer still owes us, oldest first
	body_result_t body_results_q[$];

	int unsigned err_count;
	int unsigned live_items;    // items that were not swallowed after the end
	bit          tx_gaps;       // sender inserts random gaps
	bit          rx_gaps;       // receiver inserts random stalls
	int unsigned hold_rx;       // one long receiver hold-off, picked up by the receiver

	// Scratch buffer for generated size lines
	logic [7:0] line_buf[$];

	// ------------------------------------------------------------------
	// Deframer prediction: own copy of the register and the frame state
	// ------------------------------------------------------------------
	logic [COUNT_W-1:0] cap_reg;
	logic [2:0]         frame_phase;
	logic [2:0]         parse_step;
	logic [31:0]        size_acc;
	logic               size_neg;
	int unsigned        line_count;
	int unsigned        trail_left;
	logic [COUNT_W-1:0] chunk_rem;
	logic [COUNT_W-1:0] body_count;

	function automatic void clear_size_line();
		parse_step = PS_BLANK;
		size_acc   = '0;
		size_neg   = 1'b0;
		line_count = 0;
	endfunction

	function automatic void clear_body();
		frame_phase = PH_LINE;
		clear_size_line();
		trail_left = 0;
		chunk_rem  = '0;
		body_count = '0;
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	// Magnitude sticks at all ones once another digit would overflow
	function automatic void push_digit(input int d);
		if (size_acc > 32'h0FFF_FFFF)
			size_acc = '1;
		else
			size_acc = (size_acc << 4) + d;
	endfunction

	// strtol-style scan, one character at a time
	function automatic void parse_size_char(input logic [7:0] c);
		int         d;
		logic [2:0] st;
		d  = hex_digit(c);
		st = parse_step;
		if (st == PS_BLANK) begin
			if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) return;
			if (c == "+" || c == "-") begin
				size_neg   = (c == "-");
				parse_step = PS_SIGNED;
				return;
			end
			st = PS_SIGNED;
		end
		case (st)
			PS_SIGNED: begin
				if (c == "0") parse_step = PS_ZERO;
				else if (d >= 0) begin
					push_digit(d);
					parse_step = PS_DIGITS;
				end else parse_step = PS_STOP;
			end
			PS_ZERO: begin
				if (c == "x" || c == "X") parse_step = PS_PREFIX;
				else if (d >= 0) begin
					push_digit(d);
					parse_step = PS_DIGITS;
				end else parse_step = PS_STOP;
			end
			PS_PREFIX, PS_DIGITS: begin
				if (d >= 0) begin
					push_digit(d);
					parse_step = PS_DIGITS;
				end else parse_step = PS_STOP;
			end
			default: ;
		endcase
	endfunction

	// Advance the frame state by one item; returns 1 when a result is due
	function automatic bit deframe_byte(input bit restart, input logic [7:0] c,
			output body_result_t r);
		int unsigned eff_cap;
		int unsigned room;
		r = '0;
		if (restart) begin
			clear_body();
			return 0;
		end
		case (frame_phase)
			PH_LINE: begin
				if (c == CH_CR || c == CH_LF) begin
					// zero wins over the sign, so minus zero ends the body cleanly
					if (size_acc == 0) begin
						frame_phase = PH_DONE;
						r.fin = 1'b1;
						r.len = body_count;
						return 1;
					end
					if (size_neg) begin
						frame_phase = PH_DONE;
						r.fail = 1'b1;
						r.len  = body_count;
						return 1;
					end
					frame_phase = PH_SKIP;
					return 0;
				end
				if (line_count >= SIZE_LINE_LIMIT_DEF) begin
					frame_phase = PH_DONE;
					r.fail = 1'b1;
					r.len  = body_count;
					return 1;
				end
				line_count++;
				parse_size_char(c);
				return 0;
			end
			PH_SKIP: begin
				eff_cap = (cap_reg > MAX_BODY_DEF) ? MAX_BODY_DEF : cap_reg;
				room    = (eff_cap > body_count) ? eff_cap - body_count : 0;
				chunk_rem = (size_acc < room) ? size_acc[COUNT_W-1:0] : room[COUNT_W-1:0];
				if (chunk_rem == 0) begin
					frame_phase = PH_DONE;
					r.fin = 1'b1;
					r.len = body_count;
					return 1;
				end
				frame_phase = PH_DATA;
				return 0;
			end
			PH_DATA: begin
				eff_cap = (cap_reg > MAX_BODY_DEF) ? MAX_BODY_DEF : cap_reg;
				body_count++;
				chunk_rem--;
				if (chunk_rem == 0) begin
					if (body_count >= eff_cap) begin
						frame_phase = PH_DONE;
						r.fin = 1'b1;
					end else begin
						frame_phase = PH_TRAIL;
						trail_left  = 2;
					end
				end
				r.dv  = 1'b1;
				r.b   = c;
				r.len = body_count;
				return 1;
			end
			PH_TRAIL: begin
				if (trail_left > 0) trail_left--;
				if (trail_left == 0) begin
					frame_phase = PH_LINE;
					clear_size_line();
				end
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Clock, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random stall per result, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int unsigned n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rx > 0) begin
				n       = hold_rx;
				hold_rx = 0;
			end else begin
				n = rx_gaps ? $urandom_range(0, 7) : 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted result against the oldest expectation
	// ------------------------------------------------------------------
	initial begin
		body_result_t got;
		body_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = '{dv: data_valid, b: out_byte, fin: finished, fail: failed,
					len: body_length};
				if (body_results_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: unexpected result dv=%0b byte=%02h fin=%0b fail=%0b len=%0d",
							$realtime, got.dv, got.b, got.fin, got.fail, got.len);
				end else begin
					want = body_results_q.pop_front();
					if (got !== want) begin
						err_count++;
						if (err_count <= 10) begin
							$display("%0t: mismatch exp dv=%0b byte=%02h fin=%0b fail=%0b len=%0d",
								$realtime, want.dv, want.b, want.fin, want.fail, want.len);
							$display("    got dv=%0b byte=%02h fin=%0b fail=%0b len=%0d",
								got.dv, got.b, got.fin, got.fail, got.len);
						end
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender helpers
	// ------------------------------------------------------------------

	// Offer one item, hold it until taken, then predict its result.
	// Valid stays high afterwards; wait_quiet drops it when the stream pauses.
	task automatic send_item(input bit m, input logic [7:0] b);
		int unsigned  gap;
		body_result_t r;
		gap = tx_gaps ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		if (m || frame_phase != PH_DONE) live_items++;
		if (deframe_byte(m, b, r)) body_results_q.push_back(r);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
	endtask

	task automatic send_crlf();
		send_item(1'b0, CH_CR);
		send_item(1'b0, CH_LF);
	endtask

	task automatic send_line_buf();
		int i;
		for (i = 0; i < line_buf.size(); i++) send_item(1'b0, line_buf[i]);
	endtask

	task automatic restart_body();
		send_item(1'b1, 8'($urandom));
	endtask

	// Stop offering, let every owed result come out, then allow for framing
	// bytes still in the pipe that produce nothing.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (body_results_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic write_capacity(input int unsigned v);
		wait_quiet();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v[COUNT_W-1:0];
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cap_reg = v[COUNT_W-1:0];
	endtask

	function automatic logic [7:0] hex_char(input int unsigned d, input bit up);
		if (d < 10) return 8'("0" + d);
		return up ? 8'("A" + d - 10) : 8'("a" + d - 10);
	endfunction

	// Size line in one of the many spellings strtol accepts
	function automatic void make_size_line(input logic [31:0] v, input bit neg);
		logic [7:0]  blank_set[4];
		logic [31:0] n;
		logic [7:0]  digits[$];
		bit          up;
		blank_set = '{8'h20, 8'h09, 8'h0B, 8'h0C};
		line_buf.delete();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) line_buf.push_back(blank_set[$urandom_range(0, 3)]);
		if (neg) line_buf.push_back("-");
		else if ($urandom_range(0, 4) == 0) line_buf.push_back("+");
		if ($urandom_range(0, 3) == 0) begin
			line_buf.push_back("0");
			line_buf.push_back($urandom_range(0, 1) ? "x" : "X");
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2)) line_buf.push_back("0");
		up = $urandom_range(0, 1);
		n  = v;
		do begin
			digits.push_front(hex_char(n[3:0], up));
			n = n >> 4;
		end while (n != 0);
		line_buf = {line_buf, digits};
		// chunk extension: everything after the digits is ignored
		if ($urandom_range(0, 4) == 0) begin
			line_buf.push_back(";");
			repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(33, 126)));
		end
	endfunction

	// One body: mostly well-formed chunks with random content, sometimes
	// noise, a negative size, an overlong line, a huge size or a cut-off chunk.
	task automatic random_body();
		int unsigned nchunks, sz, style, k;
		logic [7:0]  b;
		restart_body();
		nchunks = $urandom_range(1, 4);
		for (k = 0; k < nchunks; k++) begin
			style = $urandom_range(0, 99);
			if (style < 4) begin
				repeat ($urandom_range(4, 20)) send_item(1'b0, 8'($urandom));
				return;
			end
			if (style < 8) begin
				make_size_line($urandom_range(1, 300), 1'b1);
				send_line_buf();
				send_item(1'b0, $urandom_range(0, 1) ? CH_CR : CH_LF);
				repeat ($urandom_range(0, 3)) send_item(1'b0, 8'($urandom));
				return;
			end
			if (style < 11) begin
				repeat ($urandom_range(50, 53)) begin
					b = 8'($urandom);
					if (b == CH_CR || b == CH_LF) b = 8'h20;
					send_item(1'b0, b);
				end
				return;
			end
			if (style < 14 && cap_reg <= 48) begin
				make_size_line(32'hFFFF_FFFF, 1'b0);
				repeat ($urandom_range(1, 3)) line_buf.push_back("a");
				send_line_buf();
				send_crlf();
				repeat (cap_reg + 2) send_item(1'b0, 8'($urandom));
				return;
			end
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			make_size_line(sz, 1'b0);
			send_line_buf();
			send_item(1'b0, $urandom_range(0, 1) ? CH_CR : CH_LF);
			send_item(1'b0, 8'($urandom));
			if (style < 18) begin
				// chunk cut short, next body restarts mid-data
				repeat ($urandom_range(0, sz - 1)) send_item(1'b0, 8'($urandom));
				return;
			end
			repeat (sz) send_item(1'b0, 8'($urandom));
			if ($urandom_range(0, 3) == 0) begin
				send_item(1'b0, 8'($urandom));
				send_item(1'b0, 8'($urandom));
			end else begin
				send_crlf();
			end
		end
		// last chunk, occasionally spelled as minus zero or a bare 0x
		case ($urandom_range(0, 5))
			0: begin
				make_size_line(0, 1'b1);
				send_line_buf();
			end
			1: send_text("0x");
			default: begin
				make_size_line(0, 1'b0);
				send_line_buf();
			end
		endcase
		send_item(1'b0, $urandom_range(0, 1) ? CH_CR : CH_LF);
		repeat ($urandom_range(0, 2)) send_item(1'b0, 8'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Plain two-byte chunk with the extreme data bytes, zero chunk, and a
	// byte after the end that must be swallowed.
	task automatic test_framing();
		restart_body();
		send_text("2");
		send_crlf();
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_crlf();
		send_text("0");
		send_crlf();
		send_text("Z");
	endtask

	// strtol spellings: blanks, sign, prefix, extension, minus zero, bare
	// prefix, negative and saturating negative sizes
	task automatic test_size_forms();
		restart_body();
		send_text(" \t+0X2;x");
		send_crlf();
		send_text("pq");
		send_crlf();
		send_text("-0");
		send_item(1'b0, CH_LF);
		restart_body();
		send_text("0x");
		send_item(1'b0, CH_CR);
		restart_body();
		send_text("-3");
		send_item(1'b0, CH_CR);
		restart_body();
		send_text("-ffffffffff");
		send_item(1'b0, CH_CR);
	endtask

	// A line of exactly the limit is fine; one more character fails
	task automatic test_overlong_line();
		restart_body();
		repeat (SIZE_LINE_LIMIT_DEF - 1) send_item(1'b0, 8'h20);
		send_text("1");
		send_crlf();
		send_text("D");
		send_crlf();
		send_text("0");
		send_item(1'b0, CH_LF);
		restart_body();
		repeat (SIZE_LINE_LIMIT_DEF) send_item(1'b0, 8'h20);
		send_text("7");
	endtask

	// Receiver holds off for a long stretch while the sender streams a full
	// chunk back to back, so the input side has to stall.
	task automatic test_backpressure();
		write_capacity(MAX_BODY_DEF);
		tx_gaps = 1'b0;
		hold_rx = 120;
		restart_body();
		send_text("40");
		send_crlf();
		repeat (64) send_item(1'b0, 8'($urandom));
		send_crlf();
		send_text("0");
		send_crlf();
		tx_gaps = 1'b1;
	endtask

	// Capacity at both extremes, saturating size, full capacity on the last
	// byte, and a capacity shrunk to what was already delivered.
	task automatic test_capacity();
		write_capacity(3);
		restart_body();
		send_text("FFFFFFFFFF");
		send_item(1'b0, CH_LF);
		send_text("wxyz");
		write_capacity(1);
		restart_body();
		send_text("+1");
		send_crlf();
		send_text("Q");
		write_capacity(MAX_BODY_DEF);
		restart_body();
		send_text("2");
		send_crlf();
		send_text("AB");
		send_crlf();
		write_capacity(2);
		send_text("5");
		send_crlf();
		write_capacity(4095);
	endtask

	task automatic test_random();
		int unsigned live_start;
		live_start = live_items;
		while (live_items - live_start < 360) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: write_capacity(MAX_BODY_DEF);
					1: write_capacity($urandom_range(1, 16));
					2: write_capacity($urandom_range(17, 200));
					default: write_capacity($urandom_range(1, MAX_BODY_DEF));
				endcase
			end
			// occasional stretches with no idling on one or both sides
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			repeat (4) random_body();
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned guard;
		err_count  = 0;
		live_items = 0;
		tx_gaps    = 1'b1;
		rx_gaps    = 1'b1;
		hold_rx    = 0;
		cap_reg    = CAP_RESET;
		clear_body();
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		mode        <= 1'b0;
		in_byte     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_framing();
		test_size_forms();
		test_overlong_line();
		test_backpressure();
		test_capacity();
		test_random();

		in_valid <= 1'b0;
		guard = 0;
		while (body_results_q.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		err_count += body_results_q.size();
		repeat (PIPE_LAT + 6) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/hcbd_pkg.sv
hdl/hcbd_size_parse.sv
hdl/http_chunked_body_deframer.sv
sim/tb_http_chunked_body_deframer.sv
